### sv/mrm_pkg.sv
// Shared constants and types for the memory region map merge unit.
// No dependencies; imported by every module of the block.
package mrm_pkg;

    // Fixed field widths of the ports
    localparam int TAG_W     = 32;
    localparam int FIELD_W   = 48;
    localparam int CNT_OUT_W = 7;
    localparam int RIDX_W    = 6;

    // Parameter defaults
    localparam int TABLE_DEPTH_DEF   = 64;
    localparam int PENDING_DEPTH_DEF = 8;
    localparam int ADDR_BITS_DEF     = 48;

    // Upper bound on regions placed during one append
    localparam logic [16:0] STEP_BOUND = 17'd65536;

    // Modes of an input word
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_COLLIDE  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FREE     = 2'd0;
    localparam logic [1:0] CFG_LOADER   = 2'd1;
    localparam logic [1:0] CFG_KERNEL   = 2'd2;
    localparam logic [1:0] CFG_RESERVED = 2'd3;

    // Configuration reset values
    localparam logic [TAG_W-1:0] FREE_TAG_DEF     = 32'd0;
    localparam logic [TAG_W-1:0] LOADER_TAG_DEF   = 32'd1;
    localparam logic [TAG_W-1:0] KERNEL_TAG_DEF   = 32'd2;
    localparam logic [TAG_W-1:0] RESERVED_TAG_DEF = 32'd3;

    // Control of the pending stack
    typedef struct packed {
        logic push;
        logic pop;
        logic clr;
    } t_stk_ctl;

endpackage

### sv/mrm_table_ram.sv
// Region table storage: one write port and one registered read port.
// Depends on mrm_pkg.
module mrm_table_ram
    import mrm_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int WIDTH = 2 * TAG_W + 2 * ADDR_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/mrm_pend_stack.sv
// Bounded stack of regions still to be placed in the table.
// Depends on mrm_pkg (t_stk_ctl).
module mrm_pend_stack
    import mrm_pkg::*;
#(
    parameter int DEPTH     = PENDING_DEPTH_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_stk_ctl             i_ctl,
    input  logic [TAG_W-1:0]     i_tag,
    input  logic [TAG_W-1:0]     i_flags,
    input  logic [ADDR_BITS-1:0] i_start,
    input  logic [ADDR_BITS-1:0] i_size,
    output logic [TAG_W-1:0]     o_tag,
    output logic [TAG_W-1:0]     o_flags,
    output logic [ADDR_BITS-1:0] o_start,
    output logic [ADDR_BITS-1:0] o_size,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int PW  = $clog2(DEPTH + 1);
    localparam int PIW = $clog2(DEPTH);

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [TAG_W-1:0]     flags;
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] size;
    } t_entry;

    t_entry         r_mem [DEPTH];
    logic [PW-1:0]  r_top;
    logic [PW-1:0]  top_m1;
    t_entry         top_ent;

    assign o_empty = (r_top == '0);
    assign o_full  = (r_top == PW'(DEPTH));
    assign top_m1  = r_top - 1'b1;
    assign top_ent = r_mem[top_m1[PIW-1:0]];
    assign o_tag   = top_ent.tag;
    assign o_flags = top_ent.flags;
    assign o_start = top_ent.start;
    assign o_size  = top_ent.size;

    // Store a pushed word
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !o_full) begin
            r_mem[r_top[PIW-1:0]] <= '{tag: i_tag, flags: i_flags,
                                       start: i_start, size: i_size};
        end
    end

    // Advance the stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else if (i_ctl.clr) begin
            r_top <= '0;
        end else if (i_ctl.push && !o_full) begin
            r_top <= r_top + 1'b1;
        end else if (i_ctl.pop && !o_empty) begin
            r_top <= top_m1;
        end
    end

endmodule

### sv/memory_region_map_merge_unit.sv
// Memory region map merge unit: sorted region table with merge and split on append.
// Clear, unused mode and out-of-range read go straight to the output; a read waits on the table port.
// Append time grows with push passes, pops, table entries scanned and entries moved on insert
// or removal; it is set by the single table port.
// One word at a time: ready again as the result enters the output register.
// Reset (synchronous): table and stack empty, tag registers to defaults; no clearing pass.
module memory_region_map_merge_unit
    import mrm_pkg::*;
#(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int ADDR_BITS     = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [TAG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic [TAG_W-1:0]     i_region_tag,
    input  logic [TAG_W-1:0]     i_region_flags,
    input  logic [FIELD_W-1:0]   i_region_start,
    input  logic [FIELD_W-1:0]   i_region_size,
    input  logic [RIDX_W-1:0]    i_read_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [CNT_OUT_W-1:0] o_entry_count,
    output logic [TAG_W-1:0]     o_entry_tag,
    output logic [TAG_W-1:0]     o_entry_flags,
    output logic [FIELD_W-1:0]   o_entry_start,
    output logic [FIELD_W-1:0]   o_entry_size
);

    localparam int A   = ADDR_BITS;
    localparam int W   = ADDR_BITS + 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int EW  = 2 * TAG_W + 2 * ADDR_BITS;
    localparam logic [W-1:0] LIMIT = {1'b1, {A{1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDW  = 4'd1;
    localparam logic [3:0] S_PUSH = 4'd2;
    localparam logic [3:0] S_POP  = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_LD   = 4'd5;
    localparam logic [3:0] S_EV   = 4'd6;
    localparam logic [3:0] S_INS  = 4'd7;
    localparam logic [3:0] S_SHU  = 4'd8;
    localparam logic [3:0] S_SHUW = 4'd9;
    localparam logic [3:0] S_DROP = 4'd10;
    localparam logic [3:0] S_DRW  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [TAG_W-1:0] flags;
        logic [A-1:0]     start;
        logic [A-1:0]     size;
    } t_entry;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [TAG_W-1:0] flags;
        logic [W-1:0]     start;
        logic [W-1:0]     fin;
    } t_cand;

    // Tag registers
    logic [TAG_W-1:0] r_free, r_loader, r_kernel, r_reserved;

    // Sequencer state
    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_k, n_k;
    logic [16:0]      r_steps, n_steps;
    logic [1:0]       r_pi, n_pi;
    logic [2:0]       r_cv, n_cv;
    t_cand            r_cand [3];
    t_cand            n_cand [3];
    logic [TAG_W-1:0] r_t, n_t;
    logic [TAG_W-1:0] r_f, n_f;
    logic [W-1:0]     r_s, n_s;
    logic [A-1:0]     r_z, n_z;
    logic [W-1:0]     r_re, n_re;
    logic             r_mr, n_mr;
    t_entry           r_o, n_o;
    logic [W-1:0]     r_oe, n_oe;
    logic [1:0]       r_status, n_status;
    logic             r_hit, n_hit;

    // Output register
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [CNT_OUT_W-1:0] r_out_count;
    t_entry               r_out_ent;
    logic                 out_load;

    // Table and stack hookup
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] rd_data, wr_data;
    t_entry        rd_ent;
    t_stk_ctl      stk_ctl;
    logic [TAG_W-1:0] stk_tag, stk_flags;
    logic [A-1:0]  stk_start, stk_size;
    logic          stk_empty, stk_full;

    // Push unit and compare unit
    t_cand         pc;
    logic [W-1:0]  p_end, p_size;
    logic          p_skip;
    logic [W-1:0]  os, d1, d2;
    logic          same_tag, mo, m1, m2, ovl, win_a, win_b, before_os;

    logic          in_acc;
    logic [31:0]   ridx32;
    logic [63:0]   in_s64, in_z64;
    logic [A-1:0]  in_s, in_z;
    logic          rd_in_range;
    logic [CW-1:0] k_p1, k_m1;

    function automatic logic can_merge(input logic [TAG_W-1:0] t,
                                       input logic [TAG_W-1:0] a,
                                       input logic [TAG_W-1:0] b,
                                       input logic [TAG_W-1:0] c,
                                       input logic [TAG_W-1:0] d);
        return (t == a) || (t == b) || (t == c) || (t == d);
    endfunction

    mrm_table_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    mrm_pend_stack #(.DEPTH(PENDING_DEPTH), .ADDR_BITS(ADDR_BITS)) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .i_tag   (pc.tag),
        .i_flags (pc.flags),
        .i_start (pc.start[A-1:0]),
        .i_size  (p_size[A-1:0]),
        .o_tag   (stk_tag),
        .o_flags (stk_flags),
        .o_start (stk_start),
        .o_size  (stk_size),
        .o_empty (stk_empty),
        .o_full  (stk_full)
    );

    assign rd_ent     = rd_data;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Fit input fields to the address width
    assign in_s64 = 64'(i_region_start);
    assign in_z64 = 64'(i_region_size);
    assign in_s   = in_s64[A-1:0];
    assign in_z   = in_z64[A-1:0];
    assign ridx32 = 32'(i_read_index);
    assign rd_in_range = (ridx32 < 32'(r_count)) && (ridx32 < TABLE_DEPTH);

    // Clip the selected candidate to the address space
    assign pc     = r_cand[r_pi];
    assign p_end  = (pc.fin > LIMIT) ? LIMIT : pc.fin;
    assign p_size = p_end - pc.start;
    assign p_skip = !r_cv[r_pi] || (p_size == '0);

    // Compare the current region with the table entry
    assign os        = W'(r_o.start);
    assign d1        = r_re - os;
    assign d2        = r_oe - r_s;
    assign same_tag  = (r_t == r_o.tag);
    assign mo        = can_merge(r_o.tag, r_free, r_loader, r_kernel, r_reserved);
    assign m1        = same_tag && r_mr && (r_s == r_oe) && !d1[A];
    assign m2        = same_tag && r_mr && (r_re == os) && !d2[A];
    assign ovl       = (r_s < r_oe) && (os < r_re);
    assign win_a     = (r_mr && !mo) || (r_o.tag == r_free);
    assign win_b     = !r_mr && mo;
    assign before_os = (r_s < os);
    assign k_p1      = r_k + 1'b1;
    assign k_m1      = r_k - 1'b1;

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_k      = r_k;
        n_steps  = r_steps;
        n_pi     = r_pi;
        n_cv     = r_cv;
        n_cand   = r_cand;
        n_t      = r_t;
        n_f      = r_f;
        n_s      = r_s;
        n_z      = r_z;
        n_re     = r_re;
        n_mr     = r_mr;
        n_o      = r_o;
        n_oe     = r_oe;
        n_status = r_status;
        n_hit    = r_hit;
        rd_en    = 1'b0;
        rd_addr  = r_i[IW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_k[IW-1:0];
        wr_data  = rd_data;
        stk_ctl  = '0;
        out_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_status = ST_OK;
                    n_hit    = 1'b0;
                    priority if (i_mode == MODE_APPEND) begin
                        n_cand[0] = '{tag: i_region_tag, flags: i_region_flags,
                                      start: W'(in_s), fin: W'(in_s) + W'(in_z)};
                        n_cv      = 3'b001;
                        n_pi      = 2'd0;
                        n_steps   = '0;
                        n_state   = S_PUSH;
                    end else if (i_mode == MODE_READ) begin
                        if (rd_in_range) begin
                            rd_en   = 1'b1;
                            rd_addr = ridx32[IW-1:0];
                            n_state = S_RDW;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else if (i_mode == MODE_CLEAR) begin
                        n_count = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RDW: begin
                n_o     = rd_ent;
                n_hit   = 1'b1;
                n_state = S_DONE;
            end
            S_PUSH: begin
                if (!p_skip && stk_full) begin
                    n_status = ST_OVERFLOW;
                    n_state  = S_DONE;
                end else begin
                    stk_ctl.push = !p_skip;
                    if (r_pi == 2'd2) begin
                        n_state = S_POP;
                    end else begin
                        n_pi = r_pi + 1'b1;
                    end
                end
            end
            S_POP: begin
                priority if (stk_empty) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (r_steps == STEP_BOUND) begin
                    n_status = ST_OVERFLOW;
                    n_state  = S_DONE;
                end else begin
                    stk_ctl.pop = 1'b1;
                    n_steps = r_steps + 1'b1;
                    n_t     = stk_tag;
                    n_f     = stk_flags;
                    n_s     = W'(stk_start);
                    n_z     = stk_size;
                    n_re    = W'(stk_start) + W'(stk_size);
                    n_mr    = can_merge(stk_tag, r_free, r_loader, r_kernel, r_reserved);
                    n_i     = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_i == r_count) begin
                    n_state = S_INS;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_LD;
                end
            end
            S_LD: begin
                n_o     = rd_ent;
                n_oe    = W'(rd_ent.start) + W'(rd_ent.size);
                n_state = S_EV;
            end
            S_EV: begin
                n_k  = r_i;
                n_pi = 2'd0;
                priority if (m1) begin
                    n_cand[0] = '{tag: r_o.tag, flags: r_o.flags, start: os, fin: r_re};
                    n_cv      = 3'b001;
                    n_state   = S_DROP;
                end else if (m2) begin
                    n_cand[0] = '{tag: r_o.tag, flags: r_o.flags, start: r_s, fin: r_oe};
                    n_cv      = 3'b001;
                    n_state   = S_DROP;
                end else if (ovl && win_a) begin
                    n_cand[0] = '{tag: r_o.tag, flags: '0, start: r_re, fin: r_oe};
                    n_cand[1] = '{tag: r_o.tag, flags: '0, start: os, fin: r_s};
                    n_cand[2] = '{tag: r_t, flags: r_f, start: r_s, fin: r_re};
                    n_cv      = {1'b1, os < r_s, r_oe > r_re};
                    n_state   = S_DROP;
                end else if (ovl && win_b) begin
                    n_cand[0] = '{tag: r_t, flags: '0, start: r_oe, fin: r_re};
                    n_cand[1] = '{tag: r_t, flags: '0, start: r_s, fin: os};
                    n_cand[2] = '{tag: r_o.tag, flags: r_o.flags, start: os, fin: r_oe};
                    n_cv      = {1'b1, r_s < os, r_re > r_oe};
                    n_state   = S_DROP;
                end else if (ovl) begin
                    n_status = ST_COLLIDE;
                    n_state  = S_DONE;
                end else if (before_os) begin
                    n_state = S_INS;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_INS: begin
                if (r_count >= CW'(TABLE_DEPTH)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_k     = r_count;
                    n_state = S_SHU;
                end
            end
            S_SHU: begin
                if (r_k == r_i) begin
                    wr_en   = 1'b1;
                    wr_addr = r_i[IW-1:0];
                    wr_data = {r_t, r_f, r_s[A-1:0], r_z};
                    n_count = r_count + 1'b1;
                    n_state = S_POP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = k_m1[IW-1:0];
                    n_state = S_SHUW;
                end
            end
            S_SHUW: begin
                wr_en   = 1'b1;
                n_k     = k_m1;
                n_state = S_SHU;
            end
            S_DROP: begin
                if (k_p1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_PUSH;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = k_p1[IW-1:0];
                    n_state = S_DRW;
                end
            end
            S_DRW: begin
                wr_en   = 1'b1;
                n_k     = k_p1;
                n_state = S_DROP;
            end
            S_DONE: begin
                stk_ctl.clr = 1'b1;
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Hold working registers
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_k      <= n_k;
        r_steps  <= n_steps;
        r_pi     <= n_pi;
        r_cv     <= n_cv;
        r_cand   <= n_cand;
        r_t      <= n_t;
        r_f      <= n_f;
        r_s      <= n_s;
        r_z      <= n_z;
        r_re     <= n_re;
        r_mr     <= n_mr;
        r_o      <= n_o;
        r_oe     <= n_oe;
        r_status <= n_status;
        r_hit    <= n_hit;
    end

    // Write tag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free     <= FREE_TAG_DEF;
            r_loader   <= LOADER_TAG_DEF;
            r_kernel   <= KERNEL_TAG_DEF;
            r_reserved <= RESERVED_TAG_DEF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FREE:     r_free     <= i_cfg_data;
                CFG_LOADER:   r_loader   <= i_cfg_data;
                CFG_KERNEL:   r_kernel   <= i_cfg_data;
                CFG_RESERVED: r_reserved <= i_cfg_data;
            endcase
        end
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_count  <= CNT_OUT_W'(r_count);
            r_out_ent    <= r_hit ? r_o : '0;
        end
    end

    logic [63:0] out_s64, out_z64;
    assign out_s64       = 64'(r_out_ent.start);
    assign out_z64       = 64'(r_out_ent.size);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_entry_tag   = r_out_ent.tag;
    assign o_entry_flags = r_out_ent.flags;
    assign o_entry_start = out_s64[FIELD_W-1:0];
    assign o_entry_size  = out_z64[FIELD_W-1:0];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("table count above depth");

    a_idle_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> stk_empty)
        else $error("pending stack not empty while idle");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_mode == MODE_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHU) |-> (r_k >= r_i))
        else $error("insert shift passed its slot");
`endif

endmodule
